@@ src/cdrp_pkg.sv @@
// Shared types, result and status codes, and encoding name tables for the
// image message parser. No dependencies.
package cdrp_pkg;

  localparam int POS_BITS_DFLT = 32;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_TRUNCATED  = 3'd2;
  localparam logic [2:0] ST_BAD_ENC    = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;
  localparam logic [2:0] ST_SHORT_DATA = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         pixel;
    logic signed [31:0] stamp_sec;
    logic [31:0]        stamp_nanosec;
    logic [31:0]        rows;
    logic [31:0]        cols;
    logic [31:0]        row_bytes;
    logic               pixel_format;
    logic               msb_first_flag;
    logic [2:0]         status;
    logic               final_result;
  } out_item_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

  // "bgr8"
  function automatic logic [7:0] enc3_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h62;
      2'd1: c = 8'h67;
      2'd2: c = 8'h72;
      2'd3: c = 8'h38;
    endcase
    return c;
  endfunction

  // "bgra8"
  function automatic logic [7:0] enc4_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h67;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h38;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ src/cdrp_parser.sv @@
// Parse state machine: consumes one registered message byte per advance and
// produces up to two results. Depends on cdrp_pkg.
module cdrp_parser #(
  parameter int POSITION_BITS = cdrp_pkg::POS_BITS_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  cdrp_pkg::in_item_t  item,
  output cdrp_pkg::push_t     push,
  output cdrp_pkg::out_item_t res_a,
  output cdrp_pkg::out_item_t res_b
);
  import cdrp_pkg::*;

  localparam logic [3:0] PH_HDR   = 4'd0;
  localparam logic [3:0] PH_SEC   = 4'd1;
  localparam logic [3:0] PH_NSEC  = 4'd2;
  localparam logic [3:0] PH_FLEN  = 4'd3;
  localparam logic [3:0] PH_FBODY = 4'd4;
  localparam logic [3:0] PH_ROWS  = 4'd5;
  localparam logic [3:0] PH_COLS  = 4'd6;
  localparam logic [3:0] PH_ELEN  = 4'd7;
  localparam logic [3:0] PH_EBODY = 4'd8;
  localparam logic [3:0] PH_BIGE  = 4'd9;
  localparam logic [3:0] PH_STEP  = 4'd10;
  localparam logic [3:0] PH_DLEN  = 4'd11;
  localparam logic [3:0] PH_DATA  = 4'd12;
  localparam logic [3:0] PH_DONE  = 4'd13;

  logic [3:0]               phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [3:0]               wshift_r, wshift_nxt;
  logic [31:0]              left_r, left_nxt;
  logic [31:0]              acc_r, acc_nxt;
  logic [31:0]              sec_r, sec_nxt;
  logic [31:0]              nsec_r, nsec_nxt;
  logic [31:0]              rows_r, rows_nxt;
  logic [31:0]              cols_r, cols_nxt;
  logic [31:0]              step_r, step_nxt;
  logic [1:0]               match_r, match_nxt;
  logic [31:0]              pix_left_r, pix_left_nxt;
  logic [2:0]               perr_r, perr_nxt;
  logic                     bige_r, bige_nxt;
  logic [63:0]              need_r;
  logic [31:0]              word;
  logic [7:0]               b;
  logic [2:0]               st;
  out_item_t                stat;
  logic                     va, vb;

  assign b    = item.data_byte;
  assign word = {b, acc_r[23:0]};

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r + POSITION_BITS'(1);
    wshift_nxt   = wshift_r;
    left_nxt     = left_r;
    acc_nxt      = acc_r;
    sec_nxt      = sec_r;
    nsec_nxt     = nsec_r;
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    step_nxt     = step_r;
    match_nxt    = match_r;
    pix_left_nxt = pix_left_r;
    perr_nxt     = perr_r;
    bige_nxt     = bige_r;
    res_a        = '0;
    res_b        = '0;
    stat         = '0;
    st           = ST_OK;
    va           = 1'b0;
    vb           = 1'b0;

    unique case (phase_r)
      PH_HDR: begin
        if (pos_r >= POSITION_BITS'(3)) begin
          phase_nxt = PH_SEC;
        end
      end
      PH_SEC, PH_NSEC, PH_FLEN, PH_ROWS, PH_COLS, PH_ELEN, PH_STEP, PH_DLEN: begin
        if (!(wshift_r == 4'd0 && pos_r[1:0] != 2'd0)) begin
          if (wshift_r[1:0] == 2'd3) begin
            wshift_nxt = 4'd0;
            acc_nxt    = '0;
            unique case (phase_r)
              PH_SEC: begin
                sec_nxt   = word;
                phase_nxt = PH_NSEC;
              end
              PH_NSEC: begin
                nsec_nxt  = word;
                phase_nxt = PH_FLEN;
              end
              PH_FLEN: begin
                left_nxt  = word;
                phase_nxt = (word != '0) ? PH_FBODY : PH_ROWS;
              end
              PH_ROWS: begin
                rows_nxt  = word;
                phase_nxt = PH_COLS;
              end
              PH_COLS: begin
                cols_nxt  = word;
                phase_nxt = PH_ELEN;
              end
              PH_ELEN: begin
                left_nxt  = word;
                match_nxt = {word == 32'd6, word == 32'd5};
                phase_nxt = (word != '0) ? PH_EBODY : PH_BIGE;
              end
              PH_STEP: begin
                step_nxt  = word;
                phase_nxt = PH_DLEN;
              end
              default: begin
                left_nxt = word;
                priority if (match_r == 2'b00) begin
                  perr_nxt = ST_BAD_ENC;
                end else if (word == '0) begin
                  perr_nxt = ST_EMPTY;
                end else if ({32'd0, word} < need_r) begin
                  perr_nxt = ST_SHORT_DATA;
                end else begin
                  perr_nxt = ST_OK;
                end
                pix_left_nxt         = (perr_nxt != ST_OK) ? 32'd0 : need_r[31:0];
                va                   = 1'b1;
                res_a.kind           = KIND_HEADER;
                res_a.stamp_sec      = signed'(sec_r);
                res_a.stamp_nanosec  = nsec_r;
                res_a.rows           = rows_r;
                res_a.cols           = cols_r;
                res_a.row_bytes      = step_r;
                res_a.pixel_format   = match_r[1];
                res_a.msb_first_flag = bige_r;
                phase_nxt            = (word != '0) ? PH_DATA : PH_DONE;
              end
            endcase
          end else begin
            acc_nxt[{wshift_r[1:0], 3'b000} +: 8] = b;
            wshift_nxt                            = wshift_r + 4'd1;
          end
        end
      end
      PH_FBODY: begin
        left_nxt = left_r - 32'd1;
        if (left_r == 32'd1) begin
          phase_nxt = PH_ROWS;
        end
      end
      PH_EBODY: begin
        if (wshift_r < 4'd4 && b != enc3_char(wshift_r[1:0])) begin
          match_nxt[0] = 1'b0;
        end
        if (wshift_r < 4'd5 && b != enc4_char(wshift_r[2:0])) begin
          match_nxt[1] = 1'b0;
        end
        if (wshift_r < 4'd8) begin
          wshift_nxt = wshift_r + 4'd1;
        end
        left_nxt = left_r - 32'd1;
        if (left_r == 32'd1) begin
          wshift_nxt = 4'd0;
          phase_nxt  = PH_BIGE;
        end
      end
      PH_BIGE: begin
        bige_nxt  = |b;
        phase_nxt = PH_STEP;
      end
      PH_DATA: begin
        if (pix_left_r != '0) begin
          va           = 1'b1;
          res_a.kind   = KIND_PIXEL;
          res_a.pixel  = b;
          pix_left_nxt = pix_left_r - 32'd1;
        end
        left_nxt = left_r - 32'd1;
        if (left_r == 32'd1) begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (item.last_byte) begin
      priority if (phase_nxt == PH_HDR) begin
        st = ST_TOO_SHORT;
      end else if (phase_nxt != PH_DONE) begin
        st = ST_TRUNCATED;
      end else begin
        st = perr_nxt;
      end
      stat.kind         = KIND_STATUS;
      stat.status       = st;
      stat.final_result = 1'b1;
      if (va) begin
        res_b = stat;
        vb    = 1'b1;
      end else begin
        res_a = stat;
        va    = 1'b1;
      end
      phase_nxt    = PH_HDR;
      pos_nxt      = '0;
      wshift_nxt   = '0;
      left_nxt     = '0;
      acc_nxt      = '0;
      sec_nxt      = '0;
      nsec_nxt     = '0;
      rows_nxt     = '0;
      cols_nxt     = '0;
      step_nxt     = '0;
      match_nxt    = '0;
      pix_left_nxt = '0;
      perr_nxt     = ST_OK;
      bige_nxt     = 1'b0;
    end else if (va) begin
      res_a.final_result = 1'b1;
    end
  end

  assign push.push_a = adv & va;
  assign push.push_b = adv & vb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR;
      pos_r      <= '0;
      wshift_r   <= '0;
      left_r     <= '0;
      acc_r      <= '0;
      sec_r      <= '0;
      nsec_r     <= '0;
      rows_r     <= '0;
      cols_r     <= '0;
      step_r     <= '0;
      match_r    <= '0;
      pix_left_r <= '0;
      perr_r     <= ST_OK;
      bige_r     <= 1'b0;
    end else if (adv) begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      wshift_r   <= wshift_nxt;
      left_r     <= left_nxt;
      acc_r      <= acc_nxt;
      sec_r      <= sec_nxt;
      nsec_r     <= nsec_nxt;
      rows_r     <= rows_nxt;
      cols_r     <= cols_nxt;
      step_r     <= step_nxt;
      match_r    <= match_nxt;
      pix_left_r <= pix_left_nxt;
      perr_r     <= perr_nxt;
      bige_r     <= bige_nxt;
    end
  end

  // rows and step settle at least four bytes before the data length completes
  always_ff @(posedge clk) begin
    need_r <= 64'(rows_r) * 64'(step_r);
  end

  a_second_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    vb |-> (va && res_b.kind == KIND_STATUS && res_a.kind != KIND_STATUS))
    else $error("second result is not an end status");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item.last_byte) |=> (phase_r == PH_HDR && pos_r == '0 && pix_left_r == '0))
    else $error("parser did not restart after last byte");

  a_pixels_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (pix_left_r != '0) |-> (phase_r == PH_DATA || phase_r == PH_DONE))
    else $error("pixel count live outside data phase");

endmodule

@@ src/cdrp_out_queue.sv @@
// Four-entry result queue: takes up to two results per cycle, delivers one.
// Depends on cdrp_pkg.
module cdrp_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  cdrp_pkg::push_t     push,
  input  cdrp_pkg::out_item_t res_a,
  input  cdrp_pkg::out_item_t res_b,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output cdrp_pkg::out_item_t out_item
);
  import cdrp_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  out_item_t     q_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   count_r;
  logic [1:0]    n_push;
  logic          pop;

  assign n_push    = {1'b0, push.push_a} + {1'b0, push.push_b};
  assign out_valid = (count_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_item  = q_r[rp_r];
  assign space_ok  = (count_r <= (AW+1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + AW'(n_push);
      rp_r    <= rp_r + AW'(pop);
      count_r <= count_r + (AW+1)'(n_push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_a) begin
      q_r[wp_r] <= res_a;
    end
    if (push.push_b) begin
      q_r[wp_r + AW'(1)] <= res_b;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.push_a |-> space_ok)
    else $error("push into full result queue");

endmodule

@@ src/cdr_image_message_parser_top.sv @@
// Top level of the CDR image message parser: input register, parser, result
// queue. Depends on cdrp_pkg, cdrp_parser and cdrp_out_queue.
//
// Accepts one message byte per cycle. Each byte is held in the input register
// and then parsed, and yields zero, one or two results (header or pixel, then
// the end status on the last byte); results pass through the result queue
// and leave it one per cycle. Sustained rate is one byte per cycle while
// each byte yields at most one result and the output is ready; a byte
// yielding two results needs a second output transfer, paced by the
// single-read result queue. No clearing pass after reset.
module cdr_image_message_parser_top #(
  parameter int POSITION_BITS = cdrp_pkg::POS_BITS_DFLT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdrp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output cdrp_pkg::out_item_t out_item
);
  import cdrp_pkg::*;

  in_item_t  in_item_r;
  logic      in_vld_r;
  logic      space_ok;
  logic      adv;
  push_t     push;
  out_item_t res_a;
  out_item_t res_b;

  assign adv      = in_vld_r & space_ok;
  assign in_ready = ~in_vld_r | space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  cdrp_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (in_item_r),
    .push  (push),
    .res_a (res_a),
    .res_b (res_b)
  );

  cdrp_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_push_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (push.push_a || push.push_b) |-> adv)
    else $error("result pushed without a parsed byte");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for cdr_image_message_parser_top: random CDR image messages,
// a scoreboard class that predicts header, pixel and status results, and random idling.
// Depends on cdrp_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_top;
  import cdrp_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 1400;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [3:0] {
    SKIP_HDR, GET_SEC, GET_NSEC, GET_FLEN, SKIP_FRAME, GET_ROWS, GET_COLS, GET_ELEN,
    MATCH_ENC, GET_BIGE, GET_STEP, GET_DLEN, PASS_DATA, MSG_DONE
  } parse_phase_e;

  class image_msg_check;
    parse_phase_e phase;
    logic [31:0]  pos, widx, left, acc;
    logic [31:0]  sec, nsec, rows, cols, step;
    logic [1:0]   enc_ok;
    logic         bige;
    logic [63:0]  pix_left;
    logic [2:0]   hdr_err;
    out_item_t    due_results[$];
    int           mismatches;
    string        fmt3 = "bgr8";
    string        fmt4 = "bgra8";

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      phase    = SKIP_HDR;
      pos      = '0;
      widx     = '0;
      left     = '0;
      acc      = '0;
      sec      = '0;
      nsec     = '0;
      rows     = '0;
      cols     = '0;
      step     = '0;
      enc_ok   = '0;
      bige     = 1'b0;
      pix_left = '0;
      hdr_err  = ST_OK;
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0]  b;
      logic [63:0] need;
      out_item_t   res [2];
      int          n;
      b = it.data_byte;
      n = 0;
      case (phase)
        SKIP_HDR: begin
          if (pos >= 3) phase = GET_SEC;
        end
        GET_SEC, GET_NSEC, GET_FLEN, GET_ROWS, GET_COLS, GET_ELEN, GET_STEP, GET_DLEN: begin
          // drop alignment padding
          if (widx != 0 || pos[1:0] == 2'd0) begin
            acc = acc | (32'(b) << (8 * widx[1:0]));
            widx = widx + 1;
            if (widx >= 4) begin
              case (phase)
                GET_SEC: begin
                  sec = acc;
                  phase = GET_NSEC;
                end
                GET_NSEC: begin
                  nsec = acc;
                  phase = GET_FLEN;
                end
                GET_FLEN: begin
                  left = acc;
                  phase = (acc != 0) ? SKIP_FRAME : GET_ROWS;
                end
                GET_ROWS: begin
                  rows = acc;
                  phase = GET_COLS;
                end
                GET_COLS: begin
                  cols = acc;
                  phase = GET_ELEN;
                end
                GET_ELEN: begin
                  left = acc;
                  enc_ok = {acc == 32'd6, acc == 32'd5};
                  phase = (acc != 0) ? MATCH_ENC : GET_BIGE;
                end
                GET_STEP: begin
                  step = acc;
                  phase = GET_DLEN;
                end
                default: begin
                  left = acc;
                  need = {32'd0, rows} * {32'd0, step};
                  if (enc_ok == 2'b00) hdr_err = ST_BAD_ENC;
                  else if (acc == 0) hdr_err = ST_EMPTY;
                  else if ({32'd0, acc} < need) hdr_err = ST_SHORT_DATA;
                  else hdr_err = ST_OK;
                  pix_left = (hdr_err != ST_OK) ? 64'd0 : need;
                  res[n] = '0;
                  res[n].kind = KIND_HEADER;
                  res[n].stamp_sec = sec;
                  res[n].stamp_nanosec = nsec;
                  res[n].rows = rows;
                  res[n].cols = cols;
                  res[n].row_bytes = step;
                  res[n].pixel_format = enc_ok[1];
                  res[n].msb_first_flag = bige;
                  n++;
                  phase = (acc != 0) ? PASS_DATA : MSG_DONE;
                end
              endcase
              widx = '0;
              acc = '0;
            end
          end
        end
        SKIP_FRAME: begin
          left = left - 1;
          if (left == 0) phase = GET_ROWS;
        end
        MATCH_ENC: begin
          if (widx < 4 && b != fmt3[widx]) enc_ok[0] = 1'b0;
          if (widx < 5 && b != fmt4[widx]) enc_ok[1] = 1'b0;
          if (widx < 8) widx = widx + 1;
          left = left - 1;
          if (left == 0) begin
            widx = '0;
            phase = GET_BIGE;
          end
        end
        GET_BIGE: begin
          bige = (b != 8'd0);
          phase = GET_STEP;
        end
        PASS_DATA: begin
          if (pix_left != 0) begin
            res[n] = '0;
            res[n].kind = KIND_PIXEL;
            res[n].pixel = b;
            n++;
            pix_left = pix_left - 1;
          end
          left = left - 1;
          if (left == 0) phase = MSG_DONE;
        end
        default: ;
      endcase
      pos = pos + 1;
      if (it.last_byte) begin
        res[n] = '0;
        res[n].kind = KIND_STATUS;
        if (phase == SKIP_HDR) res[n].status = ST_TOO_SHORT;
        else if (phase != MSG_DONE) res[n].status = ST_TRUNCATED;
        else res[n].status = hdr_err;
        n++;
        clear();
      end
      if (n > 0) res[n - 1].final_result = 1'b1;
      for (int k = 0; k < n; k++) due_results.push_back(res[k]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result kind %0d status %0d", $time, got.kind, got.status);
        return;
      end
      exp = due_results.pop_front();
      if (got.kind !== exp.kind || got.pixel !== exp.pixel ||
          got.stamp_sec !== exp.stamp_sec || got.stamp_nanosec !== exp.stamp_nanosec ||
          got.rows !== exp.rows || got.cols !== exp.cols || got.row_bytes !== exp.row_bytes ||
          got.pixel_format !== exp.pixel_format || got.msb_first_flag !== exp.msb_first_flag ||
          got.status !== exp.status || got.final_result !== exp.final_result) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch", $time);
          $display("  expected kind %0d px %h sec %h ns %h rows %h cols %h step %h fmt %b be %b st %0d fin %b",
                   exp.kind, exp.pixel, exp.stamp_sec, exp.stamp_nanosec, exp.rows, exp.cols,
                   exp.row_bytes, exp.pixel_format, exp.msb_first_flag, exp.status,
                   exp.final_result);
          $display("  actual   kind %0d px %h sec %h ns %h rows %h cols %h step %h fmt %b be %b st %0d fin %b",
                   got.kind, got.pixel, got.stamp_sec, got.stamp_nanosec, got.rows, got.cols,
                   got.row_bytes, got.pixel_format, got.msb_first_flag, got.status,
                   got.final_result);
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  image_msg_check sb;
  logic [7:0]     msg_bytes[$];
  int             bytes_taken = 0;
  int             stall_cycles = 0;
  logic           hold_done = 1'b0;

  cdr_image_message_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_byte(in_item);
        bytes_taken++;
      end
      if (out_valid && out_ready) sb.check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAIL cdr_image_message_parser_top");
    $finish;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h8000_0000;
    if (r < 20) return 32'h7fff_ffff;
    if (r < 30) return 32'hffff_ffff;
    if (r < 40) return 32'h0;
    return $urandom;
  endfunction

  function automatic void put_word(logic [31:0] w);
    while (msg_bytes.size() % 4 != 0) msg_bytes.push_back(8'($urandom));
    for (int k = 0; k < 4; k++) msg_bytes.push_back(w[8*k +: 8]);
  endfunction

  function automatic void build_message();
    logic [31:0] rows, step, dlen;
    logic [63:0] need;
    logic [7:0]  name[$];
    string       s;
    int          flen, sel, mode;
    msg_bytes.delete();
    repeat (4) msg_bytes.push_back(8'($urandom));
    put_word(pick_word());
    put_word(pick_word());
    flen = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 9);
    put_word(flen);
    for (int k = 0; k < flen; k++)
      msg_bytes.push_back((k == flen - 1) ? 8'h00 : 8'($urandom_range(32, 126)));
    rows = $urandom_range(0, 4);
    step = $urandom_range(0, 12);
    if ($urandom_range(0, 19) == 0) begin
      rows = '1;
      step = '1;
    end
    put_word(rows);
    put_word(pick_word());
    sel = $urandom_range(0, 99);
    if (sel < 90 && !(sel >= 70 && sel < 80)) begin
      s = (sel < 35 || (sel >= 80 && sel[0])) ? "bgr8" : "bgra8";
      for (int k = 0; k < s.len(); k++) name.push_back(s[k]);
      name.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
      if (sel >= 80) name[$urandom_range(0, s.len() - 1)] ^= 8'h01 << $urandom_range(0, 7);
    end else if (sel >= 90) begin
      s = "bgra8";
      repeat ($urandom_range(1, 12))
        name.push_back((name.size() < 5 && $urandom_range(0, 1)) ? s[name.size()] : 8'($urandom));
    end
    put_word(name.size());
    foreach (name[k]) msg_bytes.push_back(name[k]);
    case ($urandom_range(0, 2))
      0: msg_bytes.push_back(8'h00);
      1: msg_bytes.push_back(8'h01);
      default: msg_bytes.push_back(8'($urandom));
    endcase
    put_word(step);
    need = {32'd0, rows} * {32'd0, step};
    mode = $urandom_range(0, 99);
    if (need > 64) dlen = $urandom_range(1, 8);
    else if (mode < 70) dlen = need[31:0] + $urandom_range(0, 3);
    else if (mode < 82) dlen = 0;
    else if (need > 1) dlen = $urandom_range(1, int'(need) - 1);
    else dlen = $urandom_range(0, 2);
    put_word(dlen);
    repeat (dlen) msg_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_message();
    logic burst;
    burst = ($urandom_range(0, 3) == 0);
    foreach (msg_bytes[i])
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1,
                (burst || $urandom_range(0, 99) < 65) ? 0 : idle_len());
  endtask

  initial begin : receiver
    forever begin
      if (!hold_done && bytes_taken >= HOLD_AFTER) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30))
        @(negedge clk);
      @(negedge clk);
      out_ready <= 1'b0;
      repeat (idle_len() - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    int cut;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    msg_bytes = '{8'h00};
    send_message();
    msg_bytes = '{8'hff, 8'h00, 8'hff};
    send_message();
    msg_bytes = '{8'h12, 8'h34, 8'h56, 8'h78};
    send_message();
    msg_bytes = '{8'h00, 8'h01, 8'h00, 8'h00, 8'hff, 8'hff};
    send_message();

    while (bytes_taken < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        msg_bytes.delete();
        repeat ($urandom_range(1, 60)) msg_bytes.push_back(8'($urandom));
      end else begin
        build_message();
      end
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
      send_message();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("PASS cdr_image_message_parser_top");
    end else begin
      $display("FAIL cdr_image_message_parser_top");
    end
    $finish;
  end

endmodule
